[hw/rtl/ecpa_pkg.sv]
package ecpa_pkg;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] x1;
      logic [63:0] y1;
      logic        first_at_infinity;
      logic [63:0] x2;
      logic [63:0] y2;
      logic        second_at_infinity;
   } req_type;

   typedef struct packed {
      logic [63:0] x3;
      logic [63:0] y3;
      logic        result_at_infinity;
      logic        noninvertible;
      logic [63:0] denominator;
   } rsp_type;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_DBL = 2'd2;

   localparam logic REG_MODULUS = 1'b0;
   localparam logic REG_CURVE_A = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RED, ST_PREP, ST_SQ, ST_T1, ST_T2, ST_T3, ST_INV,
      ST_M, ST_MM, ST_X1, ST_X2, ST_Y1, ST_MY, ST_Y2, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      INV_IDLE, INV_LOOP, INV_SHIFT, INV_SUB
   } inv_state_type;

   typedef struct packed {
      logic start;
      logic reduce;
   } mm_ctl_type;

   typedef struct packed {
      logic done;
   } mm_sts_type;

   typedef struct packed {
      logic done;
      logic ok;
   } inv_sts_type;

   // operands below n
   function automatic logic [63:0] add_m(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] n);
      logic [63:0] gap;
      gap = n - b;
      return (a >= gap) ? a - gap : a + b;
   endfunction

   function automatic logic [63:0] sub_m(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] n);
      return (a >= b) ? a - b : n - (b - a);
   endfunction

endpackage

[hw/rtl/ecpa_modmul.sv]
// Bit-serial modular multiply (double, then add) or reduction (shift bit in).
module ecpa_modmul #(
   parameter int WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ecpa_pkg::mm_ctl_type   ctl,
   input  logic [WIDTH-1:0]       op_a,
   input  logic [WIDTH-1:0]       op_b,
   input  logic [WIDTH-1:0]       modulus,
   output ecpa_pkg::mm_sts_type   sts,
   output logic [WIDTH-1:0]       result
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] acc_ff, a_ff, b_ff;
   logic [CW-1:0]    cnt_ff;
   logic             phase_ff, reduce_ff, busy_ff, done_ff;
   logic [WIDTH:0]   dbl, dbl_r, sum, sum_r, n_ext;
   logic             last;

   always_comb begin
      n_ext = {1'b0, modulus};
      dbl   = {acc_ff, 1'b0} + (WIDTH+1)'(reduce_ff & b_ff[WIDTH-1]);
      dbl_r = (dbl >= n_ext) ? dbl - n_ext : dbl;
      sum   = {1'b0, acc_ff} + {1'b0, a_ff};
      sum_r = (sum >= n_ext) ? sum - n_ext : sum;
      last  = (cnt_ff == '0) && (reduce_ff || phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         acc_ff    <= '0;
         a_ff      <= op_a;
         b_ff      <= op_b;
         cnt_ff    <= CW'(WIDTH-1);
         phase_ff  <= 1'b0;
         reduce_ff <= ctl.reduce;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_ff <= dbl_r[WIDTH-1:0];
            if (reduce_ff) begin
               b_ff   <= {b_ff[WIDTH-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               phase_ff <= 1'b1;
            end
         end else begin
            if (b_ff[WIDTH-1]) begin
               acc_ff <= sum_r[WIDTH-1:0];
            end
            b_ff     <= {b_ff[WIDTH-2:0], 1'b0};
            cnt_ff   <= cnt_ff - 1'b1;
            phase_ff <= 1'b0;
         end
      end
   end

   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

[hw/rtl/ecpa_modinv.sv]
// Shift-subtract extended gcd. Keeps r == t*d (mod n) for both pairs,
// so any subtraction order ends with gcd in r0 and the inverse in t0.
module ecpa_modinv #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WIDTH-1:0]      den,
   input  logic [WIDTH-1:0]      modulus,
   output ecpa_pkg::inv_sts_type sts,
   output logic [WIDTH-1:0]      inverse
);

   ecpa_pkg::inv_state_type st_ff, st_in;

   logic [WIDTH-1:0] r0_ff, r1_ff, t0_ff, t1_ff, rs_ff, ts_ff;
   logic             done_ff, ok_ff;
   logic [WIDTH:0]   rs2;
   logic             shift_ok;
   logic [63:0]      ts_dbl, t0_sub;

   always_comb begin
      rs2      = {rs_ff, 1'b0};
      shift_ok = rs2 <= {1'b0, r0_ff};
      ts_dbl   = ecpa_pkg::add_m(64'(ts_ff), 64'(ts_ff), 64'(modulus));
      t0_sub   = ecpa_pkg::sub_m(64'(t0_ff), 64'(ts_ff), 64'(modulus));
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ecpa_pkg::INV_IDLE:  if (start) st_in = ecpa_pkg::INV_LOOP;
         ecpa_pkg::INV_LOOP: begin
            if (r1_ff == '0) st_in = ecpa_pkg::INV_IDLE;
            else if (r0_ff >= r1_ff) st_in = ecpa_pkg::INV_SHIFT;
         end
         ecpa_pkg::INV_SHIFT: if (!shift_ok) st_in = ecpa_pkg::INV_SUB;
         ecpa_pkg::INV_SUB:   st_in = ecpa_pkg::INV_LOOP;
         default:             st_in = ecpa_pkg::INV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ecpa_pkg::INV_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= (st_ff == ecpa_pkg::INV_LOOP) && (r1_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ecpa_pkg::INV_IDLE: begin
            if (start) begin
               r0_ff <= modulus;
               r1_ff <= den;
               t0_ff <= '0;
               t1_ff <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
            end
         end
         ecpa_pkg::INV_LOOP: begin
            if (r1_ff == '0) begin
               ok_ff <= r0_ff == WIDTH'(1);
            end else if (r0_ff < r1_ff) begin
               r0_ff <= r1_ff;
               r1_ff <= r0_ff;
               t0_ff <= t1_ff;
               t1_ff <= t0_ff;
            end else begin
               rs_ff <= r1_ff;
               ts_ff <= t1_ff;
            end
         end
         ecpa_pkg::INV_SHIFT: begin
            if (shift_ok) begin
               rs_ff <= rs2[WIDTH-1:0];
               ts_ff <= ts_dbl[WIDTH-1:0];
            end
         end
         ecpa_pkg::INV_SUB: begin
            r0_ff <= r0_ff - rs_ff;
            t0_ff <= t0_sub[WIDTH-1:0];
         end
         default: ;
      endcase
   end

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;
   assign inverse  = t0_ff;

endmodule

[hw/rtl/ec_affine_point_add_mod_n_top.sv]
// Affine point add / subtract / double on y^2 = x^3 + a*x + b over Z/nZ.
// req channel: one word with command and both points, taken when req_valid
// is high and req_stall low. req_stall is high from acceptance until the
// result has moved into the rsp output register, so one item is in work at
// a time; a finished result may wait in that register while the next word
// is taken. rsp channel: one word per request, held while rsp_stall is high.
// csr port: modulus at address 0, curve_a at address 8, 64-bit data, write
// only while idle. Reset sets modulus 3, curve_a 0 and empties the block.
// Work per item: reduce the five inputs, up to four modular multiplies, plus the
// shift-subtract gcd loop, whose run time is data dependent and often dominates.
// Points at infinity, opposite points and a zero modulus finish after the
// reduction (or at once for n = 0).
module ec_affine_point_add_mod_n_top #(
   parameter int WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ecpa_pkg::req_type   req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ecpa_pkg::rsp_type   rsp_word,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   ecpa_pkg::state_type state_ff, state_in;

   logic [63:0]      modulus_ff, curve_a_ff;
   logic [WIDTH-1:0] n;
   logic [1:0]       cmd_ff;
   logic             pinf_ff, qinf_ff;
   logic [WIDTH-1:0] raw_ff [0:4];
   logic [WIDTH-1:0] red_ff [0:4];
   logic [2:0]       idx_ff;
   logic [WIDTH-1:0] px_ff, py_ff, qx_ff, num_ff, den_ff, inv_ff, m_ff, t_ff, x3_ff;
   ecpa_pkg::rsp_type res_ff, rsp_ff;
   logic             rsp_valid_ff, issued_ff;

   ecpa_pkg::mm_ctl_type  mm_ctl;
   ecpa_pkg::mm_sts_type  mm_sts;
   ecpa_pkg::inv_sts_type inv_sts;
   logic [WIDTH-1:0]      mm_a, mm_b, mm_result, inv_result;
   logic                  inv_start, accept, out_load;

   logic [WIDTH-1:0] p_x, p_y, q_x, q_y, sum_y;
   logic             q_inf, tangent, chord;

   function automatic logic [WIDTH-1:0] madd(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y,
                                             input logic [WIDTH-1:0] m);
      logic [63:0] r;
      r = ecpa_pkg::add_m(64'(x), 64'(y), 64'(m));
      return r[WIDTH-1:0];
   endfunction

   function automatic logic [WIDTH-1:0] msub(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y,
                                             input logic [WIDTH-1:0] m);
      logic [63:0] r;
      r = ecpa_pkg::sub_m(64'(x), 64'(y), 64'(m));
      return r[WIDTH-1:0];
   endfunction

   assign n         = modulus_ff[WIDTH-1:0];
   assign req_stall = state_ff != ecpa_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == ecpa_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? curve_a_ff : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 64'd3;
         curve_a_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3])
            ecpa_pkg::REG_MODULUS: modulus_ff <= csr_pwdata;
            ecpa_pkg::REG_CURVE_A: curve_a_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // operand setup after reduction
   always_comb begin
      p_x   = red_ff[1];
      p_y   = red_ff[2];
      q_x   = red_ff[3];
      q_y   = red_ff[4];
      q_inf = qinf_ff;
      case (cmd_ff)
         ecpa_pkg::CMD_DBL: begin
            q_x   = red_ff[1];
            q_y   = red_ff[2];
            q_inf = pinf_ff;
         end
         ecpa_pkg::CMD_SUB: q_y = msub('0, red_ff[4], n);
         default: ;
      endcase
      sum_y   = madd(p_y, q_y, n);
      tangent = !pinf_ff && !q_inf && (p_x == q_x) && (sum_y != '0);
      chord   = !pinf_ff && !q_inf && (p_x != q_x);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecpa_pkg::ST_IDLE:
            if (accept) state_in = (n == '0) ? ecpa_pkg::ST_OUT : ecpa_pkg::ST_RED;
         ecpa_pkg::ST_RED:
            if (mm_sts.done && idx_ff == 3'd4) state_in = ecpa_pkg::ST_PREP;
         ecpa_pkg::ST_PREP:
            state_in = tangent ? ecpa_pkg::ST_SQ :
                       chord   ? ecpa_pkg::ST_INV : ecpa_pkg::ST_OUT;
         ecpa_pkg::ST_SQ: if (mm_sts.done) state_in = ecpa_pkg::ST_T1;
         ecpa_pkg::ST_T1: state_in = ecpa_pkg::ST_T2;
         ecpa_pkg::ST_T2: state_in = ecpa_pkg::ST_T3;
         ecpa_pkg::ST_T3: state_in = ecpa_pkg::ST_INV;
         ecpa_pkg::ST_INV:
            if (inv_sts.done) state_in = inv_sts.ok ? ecpa_pkg::ST_M : ecpa_pkg::ST_OUT;
         ecpa_pkg::ST_M:  if (mm_sts.done) state_in = ecpa_pkg::ST_MM;
         ecpa_pkg::ST_MM: if (mm_sts.done) state_in = ecpa_pkg::ST_X1;
         ecpa_pkg::ST_X1: state_in = ecpa_pkg::ST_X2;
         ecpa_pkg::ST_X2: state_in = ecpa_pkg::ST_Y1;
         ecpa_pkg::ST_Y1: state_in = ecpa_pkg::ST_MY;
         ecpa_pkg::ST_MY: if (mm_sts.done) state_in = ecpa_pkg::ST_Y2;
         ecpa_pkg::ST_Y2: state_in = ecpa_pkg::ST_OUT;
         ecpa_pkg::ST_OUT: if (out_load) state_in = ecpa_pkg::ST_IDLE;
         default: state_in = ecpa_pkg::ST_IDLE;
      endcase
   end

   // unit launch and operand select
   always_comb begin
      mm_ctl.start  = 1'b0;
      mm_ctl.reduce = 1'b0;
      mm_a          = m_ff;
      mm_b          = m_ff;
      inv_start     = 1'b0;
      unique case (state_ff)
         ecpa_pkg::ST_RED: begin
            mm_ctl.start  = !issued_ff;
            mm_ctl.reduce = 1'b1;
            mm_a          = '0;
            mm_b          = raw_ff[idx_ff];
         end
         ecpa_pkg::ST_SQ: begin
            mm_ctl.start = !issued_ff;
            mm_a         = px_ff;
            mm_b         = px_ff;
         end
         ecpa_pkg::ST_M: begin
            mm_ctl.start = !issued_ff;
            mm_a         = num_ff;
            mm_b         = inv_ff;
         end
         ecpa_pkg::ST_MM: mm_ctl.start = !issued_ff;
         ecpa_pkg::ST_MY: begin
            mm_ctl.start = !issued_ff;
            mm_b         = t_ff;
         end
         ecpa_pkg::ST_INV: inv_start = !issued_ff;
         default: ;
      endcase
   end

   ecpa_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mm_ctl),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (n),
      .sts     (mm_sts),
      .result  (mm_result)
   );

   ecpa_modinv #(.WIDTH(WIDTH)) u_inv (
      .clock   (clock),
      .reset   (reset),
      .start   (inv_start),
      .den     (den_ff),
      .modulus (n),
      .sts     (inv_sts),
      .inverse (inv_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecpa_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mm_ctl.start || inv_start) begin
            issued_ff <= 1'b1;
         end else if (mm_sts.done || inv_sts.done) begin
            issued_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_ff <= res_ff;
      case (state_ff)
         ecpa_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_ff    <= req_word.command;
               pinf_ff   <= req_word.first_at_infinity;
               qinf_ff   <= req_word.second_at_infinity;
               raw_ff[0] <= curve_a_ff[WIDTH-1:0];
               raw_ff[1] <= req_word.x1[WIDTH-1:0];
               raw_ff[2] <= req_word.y1[WIDTH-1:0];
               raw_ff[3] <= req_word.x2[WIDTH-1:0];
               raw_ff[4] <= req_word.y2[WIDTH-1:0];
               idx_ff    <= '0;
               res_ff    <= '0;
            end
         end
         ecpa_pkg::ST_RED: begin
            if (mm_sts.done) begin
               red_ff[idx_ff] <= mm_result;
               idx_ff         <= idx_ff + 3'd1;
            end
         end
         ecpa_pkg::ST_PREP: begin
            px_ff  <= p_x;
            py_ff  <= p_y;
            qx_ff  <= q_x;
            num_ff <= msub(q_y, p_y, n);
            den_ff <= msub(q_x, p_x, n);
            if (pinf_ff && q_inf) begin
               res_ff.result_at_infinity <= 1'b1;
            end else if (pinf_ff) begin
               res_ff.x3 <= 64'(q_x);
               res_ff.y3 <= 64'(q_y);
            end else if (q_inf) begin
               res_ff.x3 <= 64'(p_x);
               res_ff.y3 <= 64'(p_y);
            end else if (p_x == q_x && sum_y == '0) begin
               res_ff.result_at_infinity <= 1'b1;
            end
         end
         ecpa_pkg::ST_SQ: if (mm_sts.done) t_ff <= mm_result;
         // numerator 3*x^2 + a, denominator 2*y
         ecpa_pkg::ST_T1: num_ff <= madd(t_ff, t_ff, n);
         ecpa_pkg::ST_T2: num_ff <= madd(num_ff, t_ff, n);
         ecpa_pkg::ST_T3: begin
            num_ff <= madd(num_ff, red_ff[0], n);
            den_ff <= madd(py_ff, py_ff, n);
         end
         ecpa_pkg::ST_INV: begin
            if (inv_sts.done) begin
               if (inv_sts.ok) begin
                  inv_ff <= inv_result;
               end else begin
                  res_ff.noninvertible <= 1'b1;
                  res_ff.denominator   <= 64'(den_ff);
               end
            end
         end
         ecpa_pkg::ST_M:  if (mm_sts.done) m_ff <= mm_result;
         ecpa_pkg::ST_MM: if (mm_sts.done) t_ff <= mm_result;
         ecpa_pkg::ST_X1: x3_ff <= msub(t_ff, px_ff, n);
         ecpa_pkg::ST_X2: x3_ff <= msub(x3_ff, qx_ff, n);
         ecpa_pkg::ST_Y1: t_ff <= msub(px_ff, x3_ff, n);
         ecpa_pkg::ST_MY: if (mm_sts.done) t_ff <= mm_result;
         ecpa_pkg::ST_Y2: begin
            res_ff.x3 <= 64'(x3_ff);
            res_ff.y3 <= 64'(msub(t_ff, py_ff, n));
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ecpa_pkg::ST_IDLE)
      else $error("block idle right after taking a word");

   a_noninv_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.noninvertible |->
         !rsp_word.result_at_infinity && rsp_word.x3 == '0 && rsp_word.y3 == '0)
      else $error("noninvertible result carries a point");

   a_den_only_noninv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.denominator != '0 |-> rsp_word.noninvertible)
      else $error("denominator reported without noninvertible flag");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mm_ctl.start && inv_start))
      else $error("multiplier and inverter launched together");

endmodule
